>>> sv/acb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acb_pkg
// Shared types and constants for the avcC to Annex B converter.
// ----------------------------------------------------------------------------
package acb_pkg;

  localparam int LENGTH_WIDTH_DEF = 16;
  localparam int CFG_DATA_W       = 16;
  localparam int CFG_IDX_W        = 1;

  localparam logic [CFG_IDX_W-1:0] REG_RECORD_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CAPACITY  = 1'd1;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_HEADER_SHORT = 3'd1,
    ST_COUNT_MISS   = 3'd2,
    ST_LENGTH_MISS  = 3'd3,
    ST_NAL_OVERRUN  = 3'd4,
    ST_OUTPUT_FULL  = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       record_start;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  out_byte;
    logic [2:0]  status;
    logic [15:0] total_size;
    logic [2:0]  nal_length_size;
    logic        last;
  } out_item_t;

  // Results caused by one request: an optional payload byte or an optional
  // start code, followed by an optional status.
  typedef struct packed {
    logic        has_byte;
    logic [7:0]  byte_val;
    logic        has_sc;
    logic        has_status;
    status_t     status;
    logic [15:0] total;
    logic [2:0]  nls;
  } grp_t;

endpackage
`default_nettype wire

>>> sv/acb_parse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acb_parse
// Record parser: state registers and the per-byte next-state logic.
// ----------------------------------------------------------------------------
module acb_parse #(
  parameter int LENGTH_WIDTH = acb_pkg::LENGTH_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_fire,
  input  wire acb_pkg::in_item_t              in_data,
  input  wire logic                           cfg_we,
  input  wire logic [acb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [acb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output acb_pkg::grp_t                       grp
);
  import acb_pkg::*;

  localparam int LEN_BYTES = (LENGTH_WIDTH + 7) / 8;
  localparam int CW        = ((LENGTH_WIDTH > 16) ? LENGTH_WIDTH : 16) + 2;

  typedef enum logic [2:0] {
    PH_IDLE, PH_HEADER, PH_COUNT, PH_LEN, PH_PAYLOAD, PH_DONE
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [2:0]              hidx_r, hidx_nxt;
  logic [15:0]             bleft_r, bleft_nxt;
  logic [15:0]             ocnt_r, ocnt_nxt;
  logic [7:0]              sets_r, sets_nxt;
  logic                    pps_r, pps_nxt;
  logic [LENGTH_WIDTH-1:0] pleft_r, pleft_nxt;
  logic [2:0]              lhi_r, lhi_nxt;
  logic [2:0]              lfs_r, lfs_nxt;
  logic [15:0]             rec_len_r;
  logic [15:0]             out_cap_r;

  always_comb begin
    logic                    do_next;
    logic [LENGTH_WIDTH-1:0] nal;
    logic [LENGTH_WIDTH+7:0] shifted;
    logic [7:0]              b;
    phase_nxt = phase_r;
    hidx_nxt  = hidx_r;
    bleft_nxt = bleft_r;
    ocnt_nxt  = ocnt_r;
    sets_nxt  = sets_r;
    pps_nxt   = pps_r;
    pleft_nxt = pleft_r;
    lhi_nxt   = lhi_r;
    lfs_nxt   = lfs_r;
    grp       = '0;
    do_next   = 1'b0;
    b         = in_data.in_byte;
    shifted   = {pleft_r, b};
    nal       = '0;
    if (in_fire) begin
      if (in_data.record_start) begin
        ocnt_nxt  = '0;
        sets_nxt  = '0;
        pps_nxt   = 1'b0;
        pleft_nxt = '0;
        lhi_nxt   = '0;
        lfs_nxt   = 3'd1;
        hidx_nxt  = '0;
        bleft_nxt = rec_len_r;
        if (rec_len_r < 16'd7) begin
          grp.has_status = 1'b1;
          grp.status     = ST_HEADER_SHORT;
          phase_nxt      = PH_DONE;
        end else begin
          phase_nxt = PH_HEADER;
        end
      end
      if (phase_nxt != PH_IDLE && phase_nxt != PH_DONE && bleft_nxt != '0) begin
        bleft_nxt = bleft_nxt - 16'd1;
        shifted   = {pleft_nxt, b};
        unique case (phase_nxt)
          PH_HEADER: begin
            if (hidx_nxt == 3'd4) begin
              lfs_nxt = {1'b0, b[1:0]} + 3'd1;
            end
            hidx_nxt = hidx_nxt + 3'd1;
            if (hidx_nxt >= 3'd5) begin
              phase_nxt = PH_COUNT;
              pps_nxt   = 1'b0;
              if (bleft_nxt == '0) begin
                grp.has_status = 1'b1;
                grp.status     = ST_COUNT_MISS;
                phase_nxt      = PH_DONE;
              end
            end
          end
          PH_COUNT: begin
            sets_nxt = pps_nxt ? b : {3'b000, b[4:0]};
            do_next  = 1'b1;
          end
          PH_LEN: begin
            pleft_nxt = shifted[LENGTH_WIDTH-1:0];
            lhi_nxt   = lhi_nxt + 3'd1;
            if (lhi_nxt >= 3'(LEN_BYTES)) begin
              nal = pleft_nxt;
              if (CW'(nal) > CW'(bleft_nxt)) begin
                grp.has_status = 1'b1;
                grp.status     = ST_NAL_OVERRUN;
                phase_nxt      = PH_DONE;
              end else if (CW'(ocnt_nxt) + CW'(4) + CW'(nal) > CW'(out_cap_r)) begin
                grp.has_status = 1'b1;
                grp.status     = ST_OUTPUT_FULL;
                phase_nxt      = PH_DONE;
              end else begin
                grp.has_sc = 1'b1;
                ocnt_nxt   = ocnt_nxt + 16'd4;
                sets_nxt   = sets_nxt - 8'd1;
                phase_nxt  = PH_PAYLOAD;
                if (nal == '0) begin
                  do_next = 1'b1;
                end
              end
            end
          end
          PH_PAYLOAD: begin
            grp.has_byte = 1'b1;
            grp.byte_val = b;
            ocnt_nxt     = ocnt_nxt + 16'd1;
            pleft_nxt    = pleft_nxt - LENGTH_WIDTH'(1);
            if (pleft_nxt == '0) begin
              do_next = 1'b1;
            end
          end
          default: begin
          end
        endcase
        if (do_next) begin
          if (sets_nxt != '0) begin
            phase_nxt = PH_LEN;
            lhi_nxt   = '0;
            pleft_nxt = '0;
            if (bleft_nxt < 16'(LEN_BYTES)) begin
              grp.has_status = 1'b1;
              grp.status     = ST_LENGTH_MISS;
              phase_nxt      = PH_DONE;
            end
          end else if (!pps_nxt) begin
            pps_nxt   = 1'b1;
            phase_nxt = PH_COUNT;
            if (bleft_nxt == '0) begin
              grp.has_status = 1'b1;
              grp.status     = ST_COUNT_MISS;
              phase_nxt      = PH_DONE;
            end
          end else begin
            grp.has_status = 1'b1;
            grp.status     = ST_OK;
            grp.total      = ocnt_nxt;
            phase_nxt      = PH_DONE;
          end
        end
      end
    end
    grp.nls = lfs_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      hidx_r    <= '0;
      bleft_r   <= '0;
      ocnt_r    <= '0;
      sets_r    <= '0;
      pps_r     <= 1'b0;
      pleft_r   <= '0;
      lhi_r     <= '0;
      lfs_r     <= 3'd1;
      rec_len_r <= 16'd0;
      out_cap_r <= 16'hffff;
    end else begin
      phase_r <= phase_nxt;
      hidx_r  <= hidx_nxt;
      bleft_r <= bleft_nxt;
      ocnt_r  <= ocnt_nxt;
      sets_r  <= sets_nxt;
      pps_r   <= pps_nxt;
      pleft_r <= pleft_nxt;
      lhi_r   <= lhi_nxt;
      lfs_r   <= lfs_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RECORD_LENGTH: rec_len_r <= cfg_wdata;
          REG_OUT_CAPACITY:  out_cap_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // The length field size always stays within one to four bytes.
  a_lfs_range: assert property (@(posedge clk) disable iff (!rst_n)
    (lfs_r != 3'd0) && (lfs_r <= 3'd4))
    else $error("NAL length size out of range");

  // A pending payload always has bytes left to pass.
  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (pleft_r != '0))
    else $error("payload phase with nothing left");

  // A payload byte and a start code never come from the same request.
  a_grp_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(grp.has_byte && grp.has_sc))
    else $error("payload byte and start code in one group");

endmodule
`default_nettype wire

>>> sv/acb_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acb_emit
// Result buffer: holds the results of one request and sends them one per
// cycle on the output channel while out_ready is high.
// ----------------------------------------------------------------------------
module acb_emit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_fire,
  input  wire acb_pkg::grp_t      grp,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output acb_pkg::out_item_t      out_data
);
  import acb_pkg::*;

  grp_t       grp_r;
  logic       valid_r;
  logic [2:0] pos_r;
  logic [2:0] n_cur;
  logic [2:0] n_new;
  logic [2:0] data_len;
  logic       is_last;
  logic       load;

  assign n_cur    = {2'b00, grp_r.has_byte} + (grp_r.has_sc ? 3'd4 : 3'd0)
                    + {2'b00, grp_r.has_status};
  assign n_new    = {2'b00, grp.has_byte} + (grp.has_sc ? 3'd4 : 3'd0)
                    + {2'b00, grp.has_status};
  assign data_len = grp_r.has_sc ? 3'd4 : {2'b00, grp_r.has_byte};
  assign is_last  = (pos_r == n_cur - 3'd1);
  assign load     = in_fire && (n_new != 3'd0);

  assign in_ready  = !valid_r || (out_ready && is_last);
  assign out_valid = valid_r;

  always_comb begin
    out_data                 = '0;
    out_data.nal_length_size = grp_r.nls;
    out_data.last            = is_last;
    if (pos_r < data_len) begin
      if (grp_r.has_sc) begin
        out_data.out_byte = (pos_r == 3'd3) ? 8'd1 : 8'd0;
      end else begin
        out_data.out_byte = grp_r.byte_val;
      end
    end else begin
      out_data.kind       = 1'b1;
      out_data.status     = grp_r.status;
      out_data.total_size = grp_r.total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pos_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        pos_r   <= '0;
      end else if (valid_r && out_ready) begin
        if (is_last) begin
          valid_r <= 1'b0;
        end
        pos_r <= pos_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= grp;
    end
  end

  // The read position always points inside the held group.
  a_pos_inside: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (pos_r < n_cur))
    else $error("result position beyond group");

  // A group stays until its final result has been taken.
  a_hold_group: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_ready && !is_last) |=> valid_r)
    else $error("group dropped before its final result");

  // A group only appears after a request that caused results.
  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(valid_r) |-> $past(load))
    else $error("results without a request");

endmodule
`default_nettype wire

>>> sv/avcc_config_to_annexb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// avcc_config_to_annexb
// Converts an avcC decoder configuration record, one byte per request, into
// an Annex B parameter-set stream followed by one status result.
// ----------------------------------------------------------------------------
// Timing: a request's first result is offered in the cycle after it is accepted.
// A request yields up to five results, sent one per cycle while out_ready is
// high. Throughput: one request per cycle while each causes at most one result
// and out_ready is high; a start code holds the input in the result buffer.
// Reset: synchronous, active low; parser idle, registers at their defaults.
// ----------------------------------------------------------------------------
module avcc_config_to_annexb #(
  parameter int LENGTH_WIDTH = acb_pkg::LENGTH_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire acb_pkg::in_item_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output acb_pkg::out_item_t                  out_data,
  input  wire logic                           cfg_we,
  input  wire logic [acb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [acb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import acb_pkg::*;

  grp_t grp;
  logic in_fire;

  assign in_fire = in_valid && in_ready;

  acb_parse #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .grp      (grp)
  );

  acb_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .grp      (grp),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
